// File: sv/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the sorted table insert/search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

    localparam int CAPACITY   = 8;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int POSITION_W = 3;
    localparam int TOTAL_W    = 4;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CNT_W:0]        t_sum;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [POSITION_W-1:0] t_position;
    typedef logic [TOTAL_W-1:0]    t_total;
    typedef logic [1:0]            t_cmd;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_SEARCH = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_FOUND    = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_CLEARED  = 3'd4;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    typedef struct packed {
        t_status   status;
        t_position position;
        t_total    entry_total;
    } t_out;

    // Finish event from the sequencer to the result register.
    typedef struct packed {
        logic valid;
        t_out res;
    } t_fin;

endpackage

`default_nettype wire

// File: sv/sti_ram.sv
// ----------------------------------------------------------------------------
// sti_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/sti_ctrl.sv
// ----------------------------------------------------------------------------
// sti_ctrl
// Command sequencer: insertion shift loop, binary search loop, entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire sti_pkg::t_in                       i_item,
    output logic                                    o_busy,
    output sti_pkg::t_fin                           o_fin,
    output logic                                    o_we,
    output sti_pkg::t_idx                           o_waddr,
    output logic signed [sti_pkg::VALUE_W-1:0]      o_wdata,
    output logic                                    o_re,
    output sti_pkg::t_idx                           o_raddr,
    input  wire logic signed [sti_pkg::VALUE_W-1:0] i_rdata
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS_CHK  = 5'b00010,
        S_INS_PUT  = 5'b00100,
        S_SRCH_RD  = 5'b01000,
        S_SRCH_CHK = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    sti_pkg::t_cnt                       r_count, n_count;
    sti_pkg::t_idx                       r_pos,   n_pos;
    sti_pkg::t_idx                       r_mid,   n_mid;
    sti_pkg::t_cnt                       r_low,   n_low;
    sti_pkg::t_cnt                       r_hi,    n_hi;
    logic signed [sti_pkg::VALUE_W-1:0]  r_value, n_value;
    sti_pkg::t_sum                       mid_sum;

    // floor((low + high) / 2) with high = hi - 1; hi > low when used
    assign mid_sum = sti_pkg::t_sum'(r_low) + sti_pkg::t_sum'(r_hi) - sti_pkg::t_sum'(1);
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_mid   = r_mid;
        n_low   = r_low;
        n_hi    = r_hi;
        n_value = r_value;
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = r_value;
        o_re    = 1'b0;
        o_raddr = r_pos;
        o_fin   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_item.value;
                    unique case (i_item.cmd)
                        sti_pkg::CMD_INSERT: begin
                            if (r_count == sti_pkg::t_cnt'(sti_pkg::CAPACITY)) begin
                                o_fin.valid      = 1'b1;
                                o_fin.res.status = sti_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                o_we             = 1'b1;
                                o_waddr          = '0;
                                o_wdata          = i_item.value;
                                n_count          = sti_pkg::t_cnt'(1);
                                o_fin.valid      = 1'b1;
                                o_fin.res.status = sti_pkg::ST_INSERTED;
                            end else begin
                                n_pos   = sti_pkg::t_idx'(r_count);
                                o_re    = 1'b1;
                                o_raddr = sti_pkg::t_idx'(r_count - sti_pkg::t_cnt'(1));
                                n_state = S_INS_CHK;
                            end
                        end
                        sti_pkg::CMD_SEARCH: begin
                            if (r_count == '0) begin
                                o_fin.valid      = 1'b1;
                                o_fin.res.status = sti_pkg::ST_NOTFOUND;
                            end else begin
                                n_low   = '0;
                                n_hi    = r_count;
                                n_state = S_SRCH_RD;
                            end
                        end
                        sti_pkg::CMD_CLEAR: begin
                            n_count          = '0;
                            o_fin.valid      = 1'b1;
                            o_fin.res.status = sti_pkg::ST_CLEARED;
                        end
                        default: begin
                            o_fin.valid      = 1'b1;
                            o_fin.res.status = sti_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                // i_rdata holds the entry just below r_pos
                o_we    = 1'b1;
                o_waddr = r_pos;
                if (i_rdata > r_value) begin
                    o_wdata = i_rdata;
                    n_pos   = r_pos - sti_pkg::t_idx'(1);
                    if (r_pos == sti_pkg::t_idx'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_pos - sti_pkg::t_idx'(2);
                    end
                end else begin
                    o_wdata            = r_value;
                    n_count            = r_count + sti_pkg::t_cnt'(1);
                    o_fin.valid        = 1'b1;
                    o_fin.res.status   = sti_pkg::ST_INSERTED;
                    o_fin.res.position = sti_pkg::t_position'(r_pos);
                    n_state            = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_we             = 1'b1;
                o_waddr          = '0;
                o_wdata          = r_value;
                n_count          = r_count + sti_pkg::t_cnt'(1);
                o_fin.valid      = 1'b1;
                o_fin.res.status = sti_pkg::ST_INSERTED;
                n_state          = S_IDLE;
            end
            S_SRCH_RD: begin
                if (r_low < r_hi) begin
                    n_mid   = sti_pkg::t_idx'(mid_sum >> 1);
                    o_re    = 1'b1;
                    o_raddr = sti_pkg::t_idx'(mid_sum >> 1);
                    n_state = S_SRCH_CHK;
                end else begin
                    o_fin.valid      = 1'b1;
                    o_fin.res.status = sti_pkg::ST_NOTFOUND;
                    n_state          = S_IDLE;
                end
            end
            S_SRCH_CHK: begin
                if (i_rdata == r_value) begin
                    o_fin.valid        = 1'b1;
                    o_fin.res.status   = sti_pkg::ST_FOUND;
                    o_fin.res.position = sti_pkg::t_position'(r_mid);
                    n_state            = S_IDLE;
                end else begin
                    if (r_value < i_rdata) begin
                        n_hi = sti_pkg::t_cnt'(r_mid);
                    end else begin
                        n_low = sti_pkg::t_cnt'(r_mid) + sti_pkg::t_cnt'(1);
                    end
                    n_state = S_SRCH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_fin.res.entry_total = sti_pkg::t_total'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_mid   <= n_mid;
        r_low   <= n_low;
        r_hi    <= n_hi;
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// File: sv/sorted_table_insert_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search_unit
// Sorted table of signed 32-bit values with insert, binary search and clear.
// ----------------------------------------------------------------------------
// A command beat is taken on a clock edge with start high and busy low; the
// answer shows on o_result for exactly one cycle with o_done high, and the
// receiver cannot stall it. Clear, an insert into an empty or full table, a
// search of an empty table and the unused command finish in the accept cycle
// (o_done on the next cycle, busy never rises). An insert that moves larger
// entries up holds busy while the shift loop reads one entry and writes one
// entry per cycle through the table RAM's two ports, then writes the new
// value. Each search probe issues the address, then checks the registered
// RAM data; a miss ends on a final bound test. A new command may be given
// in the same cycle as o_done.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_search_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire sti_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_done,
    output sti_pkg::t_out      o_result
);

    sti_pkg::t_fin                      fin;
    logic                               ram_we;
    sti_pkg::t_idx                      ram_waddr;
    logic signed [sti_pkg::VALUE_W-1:0] ram_wdata;
    logic                               ram_re;
    sti_pkg::t_idx                      ram_raddr;
    logic        [sti_pkg::VALUE_W-1:0] ram_rdata;

    logic          r_done;
    sti_pkg::t_out r_result;

    // Sequencer: decodes the command and walks the table through the RAM
    sti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_fin   (fin),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata ($signed(ram_rdata))
    );

    // Table contents, kept in ascending order; only entries below the count
    // are ever read, so no clearing is needed.
    sti_ram #(
        .DEPTH (sti_pkg::CAPACITY),
        .WIDTH (sti_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register: one-cycle strobe, payload held until the next beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin.valid) begin
            r_result <= fin.res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sv/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks for the sorted table unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire sti_pkg::t_in  i_item,
    input wire logic          busy,
    input wire logic          o_done,
    input wire sti_pkg::t_out o_result
);

    // An accepted beat either finishes at once or keeps the unit busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command made no progress");

    // A result never appears while a command is still in work
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Every result traces back to an accepted beat or a busy cycle
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // Entry count never passes the table size
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.entry_total <= sti_pkg::t_total'(sti_pkg::CAPACITY)))
        else $error("entry total beyond capacity");

    // A clear leaves an empty table and reports position zero
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == sti_pkg::ST_CLEARED)
            |-> (o_result.entry_total == '0 && o_result.position == '0))
        else $error("clear left entries");

endmodule

bind sorted_table_insert_search_unit sti_checker u_sti_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
